[sv/tdbd_pkg.sv]
// Shared types, constants and codes of the telemetry data block deframer.
package tdbd_pkg;

   // Default geometry of the minor frame and of the assembled block.
   localparam int unsigned FRAME_BYTES_DEFAULT     = 42;
   localparam int unsigned SUBFRAME_STRIDE_DEFAULT = 40;

   // Frame identifiers and subframe lengths from the header byte.
   localparam logic [7:0] ID_FIRST      = 8'h14;
   localparam logic [7:0] ID_SECOND     = 8'h6F;
   localparam logic [5:0] BPS_FULL      = 6'd40;
   localparam logic [5:0] BPS_HDB_SHORT = 6'd33;
   localparam logic [5:0] BPS_EDB_SHORT = 6'd37;

   // Register reset values.
   localparam logic [4:0] EDB_MIN_RESET = 5'd6;
   localparam logic [4:0] EDB_MAX_RESET = 5'd20;
   localparam logic [4:0] HDB_CNT_RESET = 5'd7;

   // Most results one item can cause, and the depth of the result queue.
   localparam int unsigned SLOTS        = 3;
   localparam int unsigned RESULT_DEPTH = 4;
   localparam int unsigned SLOT_CNT_W   = $clog2(SLOTS + 1);

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_EDB_MIN = 2'd0;
   localparam logic [1:0] CSR_EDB_MAX = 2'd1;
   localparam logic [1:0] CSR_HDB_CNT = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_DATA       = 2'd0;
   localparam logic [1:0] KIND_EDB_REJECT = 2'd1;
   localparam logic [1:0] KIND_HDB_REJECT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [5:0] byte_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  block_byte;
      logic [10:0] block_offset;
      logic        is_edb;
      logic [5:0]  spin_number;
      logic        high_bit_rate;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] edb_min_subframes;
      logic [4:0] edb_max_subframes;
      logic [4:0] hdb_subframes;
   } cfg_type;

   // Results of one item, handed from the engine to the result queue.
   typedef struct packed {
      logic [SLOT_CNT_W-1:0] num;
      rsp_type [SLOTS-1:0]   slot;
   } push_type;

endpackage

[sv/tdbd_engine.sv]
// Input register, frame search and block collection state of the deframer.
module tdbd_engine #(
   parameter int unsigned FRAME_BYTES     = tdbd_pkg::FRAME_BYTES_DEFAULT,
   parameter int unsigned SUBFRAME_STRIDE = tdbd_pkg::SUBFRAME_STRIDE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tdbd_pkg::req_type  in_data,
   input  tdbd_pkg::cfg_type  cfg,
   input  logic               room,
   output tdbd_pkg::push_type push
);
   import tdbd_pkg::*;

   typedef enum logic {MODE_SEARCH, MODE_COLLECT} mode_type;

   // Input register.
   logic    stage_valid_ff;
   req_type stage_ff;

   // Deframer state.
   mode_type   mode_ff, mode_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       matches_ff, matches_in;
   logic [4:0] total_ff, total_in;
   logic [4:0] count_ff, count_in;
   logic [5:0] bps_ff, bps_in;
   logic       edb_ff, edb_in;
   logic [5:0] spin_ff, spin_in;
   logic       rate_ff, rate_in;

   logic       advance;
   logic [7:0] b;
   logic [5:0] pos;
   logic [5:0] sub_len;
   logic       hdr_edb;
   logic [4:0] hdr_cnt;
   logic       hdr_ok;
   logic       search_now;
   logic       data_last;
   logic [SLOT_CNT_W-1:0] num;
   rsp_type [SLOTS-1:0]   slot;

   // A data byte result at the given subframe and position.
   function automatic rsp_type data_result(input logic [7:0] value, input logic [5:0] where,
                                           input logic [4:0] sub, input logic edb,
                                           input logic [5:0] spin, input logic rate,
                                           input logic is_last);
      rsp_type r;
      r.kind          = KIND_DATA;
      r.block_byte    = value;
      r.block_offset  = 11'(sub) * 11'(SUBFRAME_STRIDE) + 11'(where);
      r.is_edb        = edb;
      r.spin_number   = (edb && (sub != '0 || where >= 6'd3)) ? spin : '0;
      r.high_bit_rate = rate;
      r.last          = is_last;
      return r;
   endfunction

   // The stage moves on only when the result queue can take a full set of results.
   assign advance  = stage_valid_ff && room;
   assign in_ready = !stage_valid_ff || room;

   assign b   = stage_ff.data_byte;
   assign pos = stage_ff.byte_index;

   // Subframe length, capped at the minor frame length.
   assign sub_len = ({1'b0, bps_ff} < 7'(FRAME_BYTES)) ? bps_ff : 6'(FRAME_BYTES);

   // Header byte decode.
   assign hdr_edb = !b[5];
   assign hdr_cnt = b[4:0];
   assign hdr_ok  = hdr_edb ? (hdr_cnt >= cfg.edb_min_subframes &&
                               hdr_cnt <= cfg.edb_max_subframes)
                            : (hdr_cnt == cfg.hdb_subframes);

   // Next state and results of the item in the input register.
   always_comb begin
      mode_in    = mode_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      matches_in = matches_ff;
      total_in   = total_ff;
      count_in   = count_ff;
      bps_in     = bps_ff;
      edb_in     = edb_ff;
      spin_in    = spin_ff;
      rate_in    = rate_ff;
      search_now = 1'b0;
      data_last  = 1'b0;
      num        = '0;
      slot       = '0;
      if ({1'b0, pos} < 7'(FRAME_BYTES)) begin
         if (mode_ff == MODE_COLLECT) begin
            if (pos == '0 && ({1'b0, count_ff} + 6'd1 >= {1'b0, total_ff})) begin
               // A frame start past the last subframe ends the block unmarked.
               mode_in    = MODE_SEARCH;
               search_now = 1'b1;
            end else begin
               if (pos == '0) begin
                  count_in = count_ff + 5'd1;
               end
               if (count_in == '0 && pos == 6'd3 && edb_ff) begin
                  spin_in = b[7:2];
               end
               if (pos < sub_len) begin
                  data_last = ({1'b0, count_in} + 6'd1 == {1'b0, total_ff}) &&
                              ({1'b0, pos} + 7'd1 == {1'b0, sub_len});
                  slot[0] = data_result(b, pos, count_in, edb_ff, spin_in, rate_ff,
                                        data_last);
                  num = SLOT_CNT_W'(1);
                  if (data_last) begin
                     mode_in    = MODE_SEARCH;
                     matches_in = 1'b0;
                  end
               end
            end
         end else begin
            search_now = 1'b1;
         end

         // Frame search on the identifier bytes and the header byte.
         if (search_now) begin
            if (pos == 6'd0) begin
               first_in   = b;
               second_in  = '0;
               matches_in = 1'b1;
            end else if (pos == 6'd1) begin
               second_in = b;
            end else if (pos == 6'd2 && matches_ff) begin
               matches_in = 1'b0;
               if (first_ff == ID_FIRST && second_ff == ID_SECOND) begin
                  edb_in  = hdr_edb;
                  rate_in = b[7];
                  bps_in  = b[6] ? BPS_FULL : (hdr_edb ? BPS_EDB_SHORT : BPS_HDB_SHORT);
                  spin_in = '0;
                  if (!hdr_ok) begin
                     slot[0].kind          = hdr_edb ? KIND_EDB_REJECT : KIND_HDB_REJECT;
                     slot[0].is_edb        = hdr_edb;
                     slot[0].high_bit_rate = b[7];
                     slot[0].last          = 1'b1;
                     num = SLOT_CNT_W'(1);
                  end else if (hdr_cnt != '0) begin
                     // The subframe is at least four bytes long, so none of the
                     // three header frame bytes can close the block.
                     total_in = hdr_cnt;
                     count_in = '0;
                     mode_in  = MODE_COLLECT;
                     slot[0]  = data_result(first_ff, 6'd0, 5'd0, hdr_edb, 6'd0, b[7], 1'b0);
                     slot[1]  = data_result(second_ff, 6'd1, 5'd0, hdr_edb, 6'd0, b[7], 1'b0);
                     slot[2]  = data_result(b, 6'd2, 5'd0, hdr_edb, 6'd0, b[7], 1'b0);
                     num = SLOT_CNT_W'(SLOTS);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      push.num  = advance ? num : '0;
      push.slot = slot;
   end

   // Input register and deframer state.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_ff <= in_data;
      end
      if (reset) begin
         stage_valid_ff <= 1'b0;
         mode_ff        <= MODE_SEARCH;
         first_ff       <= '0;
         second_ff      <= '0;
         matches_ff     <= 1'b0;
         total_ff       <= '0;
         count_ff       <= '0;
         bps_ff         <= '0;
         edb_ff         <= 1'b0;
         spin_ff        <= '0;
         rate_ff        <= 1'b0;
      end else begin
         if (in_ready) begin
            stage_valid_ff <= in_valid;
         end
         if (advance) begin
            mode_ff    <= mode_in;
            first_ff   <= first_in;
            second_ff  <= second_in;
            matches_ff <= matches_in;
            total_ff   <= total_in;
            count_ff   <= count_in;
            bps_ff     <= bps_in;
            edb_ff     <= edb_in;
            spin_ff    <= spin_in;
            rate_ff    <= rate_in;
         end
      end
   end

endmodule

[sv/tdbd_result_fifo.sv]
// Result queue that takes up to three results a cycle and sends one a beat.
module tdbd_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  tdbd_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tdbd_pkg::rsp_type  rsp_data
);
   import tdbd_pkg::*;

   // The depth is a power of two so that the pointers wrap by themselves.
   localparam int unsigned PTR_W = $clog2(RESULT_DEPTH);
   localparam int unsigned CNT_W = $clog2(RESULT_DEPTH + 1);

   rsp_type            entry_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   // Room for a full set of results, judged on registered state only.
   assign room = count_ff <= CNT_W'(RESULT_DEPTH - SLOTS);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   // Result storage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (SLOT_CNT_W'(i) < push.num) begin
            entry_ff[wr_ptr_ff + PTR_W'(i)] <= push.slot[i];
         end
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/telemetry_data_block_deframer_core.sv]
// Top level of the telemetry data block deframer.
//
// Minor-frame bytes enter on the req_ channel, one beat per byte with its
// position in the minor frame. Results leave on the rsp_ channel, one beat per
// result: block data bytes with their block offset, or a single rejection beat
// for a header whose subframe count is not accepted. The csr_ channel writes
// the three count limits and is always ready; the user is to write it only
// while idle, which the block itself does not enforce. An input beat is held
// in the input register and is then judged against the frame state; its
// results enter a four-entry result queue. Throughput is one input beat per
// cycle while the queue has room. A header byte that starts a block causes
// three results and so takes three output beats.
// When the receiver stalls, the queue keeps up to four results; input beats
// are still taken while at most one result waits, and then req_ready drops.
// Reset clears the frame state, the queue and the registers to their defaults
// (EDB range 6 to 20, HDB count 7) and the search starts from scratch.
module telemetry_data_block_deframer_core #(
   parameter int unsigned FRAME_BYTES     = tdbd_pkg::FRAME_BYTES_DEFAULT,
   parameter int unsigned SUBFRAME_STRIDE = tdbd_pkg::SUBFRAME_STRIDE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tdbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tdbd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_data
);
   import tdbd_pkg::*;

   cfg_type  cfg_ff;
   push_type push;
   logic     room;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edb_min_subframes <= EDB_MIN_RESET;
         cfg_ff.edb_max_subframes <= EDB_MAX_RESET;
         cfg_ff.hdb_subframes     <= HDB_CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EDB_MIN: cfg_ff.edb_min_subframes <= csr_data;
            CSR_EDB_MAX: cfg_ff.edb_max_subframes <= csr_data;
            CSR_HDB_CNT: cfg_ff.hdb_subframes     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Frame search and block collection.
   tdbd_engine #(
      .FRAME_BYTES     (FRAME_BYTES),
      .SUBFRAME_STRIDE (SUBFRAME_STRIDE)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_data  (req_data),
      .cfg      (cfg_ff),
      .room     (room),
      .push     (push)
   );

   // Result queue toward the receiver.
   tdbd_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // The queue comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result queue not empty after reset");

   // A rejection beat is always a single marked beat at offset zero.
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DATA |->
         rsp_data.last && rsp_data.block_offset == '0 && rsp_data.spin_number == '0)
      else $error("malformed rejection result");

   // Only the three defined kinds leave the block.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind == KIND_DATA || rsp_data.kind == KIND_EDB_REJECT ||
                    rsp_data.kind == KIND_HDB_REJECT)
      else $error("undefined result kind");

   // HDB blocks carry no spin number.
   a_hdb_no_spin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_edb |-> rsp_data.spin_number == '0)
      else $error("spin number on an HDB result");
`endif

endmodule

[verif/tb_telemetry_data_block_deframer_core.sv]
// Self-checking testbench for the telemetry data block deframer core.
`timescale 1ns / 1ps

module tb_telemetry_data_block_deframer_core;
   import tdbd_pkg::*;

   localparam int FRAME_LEN      = FRAME_BYTES_DEFAULT;
   localparam int STRIDE         = SUBFRAME_STRIDE_DEFAULT;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic {HUNTING, COLLECTING} deframe_mode_type;

   // Tracks the frame hunt and block assembly, and holds the block beats still due.
   class block_tracker;
      logic [4:0]       edb_min;
      logic [4:0]       edb_max;
      logic [4:0]       hdb_count;
      deframe_mode_type mode;
      logic [7:0]       id_first_seen;
      logic [7:0]       id_second_seen;
      logic             frame_open;
      logic [4:0]       sub_total;
      logic [4:0]       sub_index;
      logic [5:0]       sub_bytes;
      logic             edb_block;
      logic [5:0]       spin_id;
      logic             rate_high;
      rsp_type          block_beats_due[$];
      int               errors;

      function new();
         edb_min        = EDB_MIN_RESET;
         edb_max        = EDB_MAX_RESET;
         hdb_count      = HDB_CNT_RESET;
         mode           = HUNTING;
         id_first_seen  = '0;
         id_second_seen = '0;
         frame_open     = 1'b0;
         sub_total      = '0;
         sub_index      = '0;
         sub_bytes      = '0;
         edb_block      = 1'b0;
         spin_id        = '0;
         rate_high      = 1'b0;
         errors         = 0;
      endfunction

      function void write_limit(logic [1:0] idx, logic [4:0] value);
         case (idx)
            CSR_EDB_MIN: edb_min = value;
            CSR_EDB_MAX: edb_max = value;
            CSR_HDB_CNT: hdb_count = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return block_beats_due.size();
      endfunction

      function int segment_len();
         return (int'(sub_bytes) < FRAME_LEN) ? int'(sub_bytes) : FRAME_LEN;
      endfunction

      function void put_beat(logic [1:0] kind, logic [7:0] b, logic [10:0] offset,
                             logic [5:0] spin, logic fin);
         rsp_type beat;
         beat.kind          = kind;
         beat.block_byte    = b;
         beat.block_offset  = offset;
         beat.is_edb        = edb_block;
         beat.spin_number   = spin;
         beat.high_bit_rate = rate_high;
         beat.last          = fin;
         block_beats_due.push_back(beat);
      endfunction

      // One block data byte; the final byte of the final subframe closes the block.
      function void emit_data(logic [7:0] b, int pos);
         logic [5:0] spin;
         logic       fin;
         spin = (edb_block && (sub_index != 0 || pos >= 3)) ? spin_id : 6'd0;
         fin  = (int'(sub_index) + 1 == int'(sub_total)) && (pos + 1 == segment_len());
         if (fin) begin
            mode       = HUNTING;
            frame_open = 1'b0;
         end
         put_beat(KIND_DATA, b, 11'(int'(sub_index) * STRIDE + pos), spin, fin);
      endfunction

      // Advances the deframer by one accepted input beat.
      function void note_byte(req_type r);
         logic [7:0] b;
         int         pos;
         logic [4:0] cnt;
         logic       is_edb_hdr;
         logic       accept;
         b   = r.data_byte;
         pos = int'(r.byte_index);
         if (pos >= FRAME_LEN) return;

         // Collecting: a position 0 opens the next subframe or ends the block.
         if (mode == COLLECTING) begin
            if (pos == 0) begin
               if (int'(sub_index) + 1 >= int'(sub_total)) mode = HUNTING;
               else sub_index = sub_index + 5'd1;
            end
            if (mode == COLLECTING) begin
               if (sub_index == 0 && pos == 3 && edb_block) spin_id = b[7:2];
               if (pos < segment_len()) emit_data(b, pos);
               return;
            end
         end

         // Hunting for the frame identifiers.
         if (pos == 0) begin
            id_first_seen  = b;
            id_second_seen = '0;
            frame_open     = 1'b1;
         end else if (pos == 1) begin
            id_second_seen = b;
         end else if (pos == 2 && frame_open) begin
            frame_open = 1'b0;
            if (id_first_seen == ID_FIRST && id_second_seen == ID_SECOND) begin
               cnt        = b[4:0];
               is_edb_hdr = !b[5];
               edb_block  = is_edb_hdr;
               rate_high  = b[7];
               sub_bytes  = b[6] ? BPS_FULL : (is_edb_hdr ? BPS_EDB_SHORT : BPS_HDB_SHORT);
               accept     = is_edb_hdr ? (cnt >= edb_min && cnt <= edb_max)
                                       : (cnt == hdb_count);
               spin_id    = '0;
               if (!accept) begin
                  put_beat(is_edb_hdr ? KIND_EDB_REJECT : KIND_HDB_REJECT,
                           8'h00, 11'd0, 6'd0, 1'b1);
                  return;
               end
               if (cnt == 0) return;
               sub_total = cnt;
               sub_index = '0;
               mode      = COLLECTING;
               emit_data(id_first_seen, 0);
               emit_data(id_second_seen, 1);
               if (mode == COLLECTING) emit_data(b, 2);
            end
         end
      endfunction

      function void compare_field(string name, logic [10:0] want, logic [10:0] got);
         if (got !== want) begin
            $display("%0t: block beat %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            errors++;
         end
      endfunction

      // Compares an output beat with the oldest block beat due.
      function void check_beat(rsp_type got);
         rsp_type want;
         if (block_beats_due.size() == 0) begin
            $display("%0t: unexpected block beat, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = block_beats_due.pop_front();
         compare_field("kind", 11'(want.kind), 11'(got.kind));
         compare_field("block_byte", 11'(want.block_byte), 11'(got.block_byte));
         compare_field("block_offset", want.block_offset, got.block_offset);
         compare_field("is_edb", 11'(want.is_edb), 11'(got.is_edb));
         compare_field("spin_number", 11'(want.spin_number), 11'(got.spin_number));
         compare_field("high_bit_rate", 11'(want.high_bit_rate), 11'(got.high_bit_rate));
         compare_field("last", 11'(want.last), 11'(got.last));
      endfunction
   endclass

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_EDB_MIN;
   logic [4:0] csr_data  = '0;

   block_tracker tracker;
   req_type      minor_bytes_q[$];
   int           queued_bytes = 0;
   int           sink_left    = 0;
   logic [1:0]   sink_mode    = 2'd0;

   telemetry_data_block_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: switches between free flow, random and sparse acceptance, and full stalls.
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= 2'($urandom_range(0, 3));
         sink_left <= $urandom_range(1, 60);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= 1'b0;
      endcase
   end

   // Every accepted output beat is checked against the oldest block beat due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_beat(rsp_data);
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic add_item(logic [7:0] b, int p);
      req_type item;
      item.data_byte  = b;
      item.byte_index = 6'(p);
      minor_bytes_q.push_back(item);
      queued_bytes++;
   endtask

   // One subframe body: full, cut short, sparse, or at most its opening byte and one more.
   task automatic add_subframe(int first, int bps, bit final_sub);
      int style;
      int p;
      int k;
      style = $urandom_range(0, 7);
      if (first == 0 && !final_sub && $urandom_range(0, 3) != 0) style = 7;
      case (style)
         0: begin
            for (p = first; p < FRAME_LEN; p++) add_item(8'($urandom), p);
         end
         1: begin
            k = $urandom_range(first, bps - 2);
            for (p = first; p <= k; p++) add_item(8'($urandom), p);
         end
         2, 3, 4: begin
            for (p = first; p < 4; p++) add_item(8'($urandom), p);
            if ($urandom_range(0, 3) == 0) add_item(8'($urandom), 3);
            repeat ($urandom_range(0, 2)) add_item(8'($urandom), $urandom_range(4, bps - 2));
            add_item(8'($urandom), bps - 1);
            if ($urandom_range(0, 3) == 0) add_item(8'($urandom), $urandom_range(bps, 63));
         end
         default: begin
            if (first == 0) add_item(8'($urandom), 0);
            if (final_sub) add_item(8'($urandom), bps - 1);
            else if ($urandom_range(0, 1) == 0)
               add_item(8'($urandom), $urandom_range(1, bps - 2));
         end
      endcase
   endtask

   // A header frame followed by its subframes, with the count mostly in range.
   task automatic add_block();
      bit         hdb;
      bit         wide;
      bit         rate;
      int         lo;
      int         hi;
      int         cnt;
      int         frames;
      int         bps;
      int         s;
      logic [7:0] hdr;
      hdb  = 1'($urandom_range(0, 1));
      wide = 1'($urandom_range(0, 1));
      rate = 1'($urandom_range(0, 1));
      lo   = hdb ? int'(tracker.hdb_count) : int'(tracker.edb_min);
      hi   = hdb ? int'(tracker.hdb_count) : int'(tracker.edb_max);
      if (lo <= hi && $urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 3))
            0: cnt = lo;
            1: cnt = hi;
            default: cnt = $urandom_range(lo, hi);
         endcase
      end else begin
         cnt = $urandom_range(0, 31);
      end
      frames = (cnt >= lo && cnt <= hi && cnt > 0) ? cnt : 1;
      bps    = wide ? int'(BPS_FULL) : (hdb ? int'(BPS_HDB_SHORT) : int'(BPS_EDB_SHORT));
      hdr    = {rate, wide, hdb, 5'(cnt)};
      add_item(ID_FIRST, 0);
      add_item(ID_SECOND, 1);
      add_item(hdr, 2);
      add_subframe(3, bps, frames == 1);
      for (s = 1; s < frames; s++) add_subframe(0, bps, s == frames - 1);
   endtask

   // Near misses of a frame start.
   task automatic add_broken();
      case ($urandom_range(0, 3))
         0: begin
            add_item(ID_FIRST ^ (8'd1 << $urandom_range(0, 7)), 0);
            add_item(ID_SECOND, 1);
            add_item(8'($urandom), 2);
         end
         1: begin
            add_item(ID_FIRST, 0);
            add_item(ID_SECOND ^ (8'd1 << $urandom_range(0, 7)), 1);
            add_item(8'($urandom), 2);
         end
         2: begin
            // A second frame start clears the second identifier.
            add_item(ID_FIRST, 0);
            add_item(ID_SECOND, 1);
            add_item(ID_FIRST, 0);
            add_item(8'($urandom), 2);
         end
         default: begin
            add_item(ID_SECOND, 1);
            add_item(8'($urandom), 2);
            add_item(8'($urandom), 2);
         end
      endcase
   endtask

   task automatic gen_random(int budget);
      int start;
      start = queued_bytes;
      while (queued_bytes - start < budget) begin
         case ($urandom_range(0, 9))
            7, 8: add_broken();
            9: repeat ($urandom_range(1, 6)) add_item(8'($urandom), $urandom_range(0, 63));
            default: add_block();
         endcase
      end
   endtask

   // Out-of-range positions, both rejections, and one full EDB block at reset limits.
   task automatic gen_directed();
      add_item(8'hFF, 63);
      add_item(8'h00, FRAME_LEN);
      // HDB with five subframes against an expected seven.
      add_item(ID_FIRST, 0);
      add_item(ID_SECOND, 1);
      add_item(8'h25, 2);
      // EDB with 21 subframes, above the upper limit, at high bit rate.
      add_item(ID_FIRST, 0);
      add_item(ID_SECOND, 1);
      add_item(8'h95, 2);
      // EDB with six 40-byte subframes; spin reloaded by a repeat of position 3.
      add_item(ID_FIRST, 0);
      add_item(ID_SECOND, 1);
      add_item(8'hC6, 2);
      add_item(8'hFF, 3);
      add_item(8'hA8, 3);
      add_item(8'h00, FRAME_LEN - 1);
      add_item(8'h00, 0);
      add_item(8'hFF, 0);
      add_item(8'h55, 0);
      add_item(8'hAA, 0);
      add_item(8'h01, 0);
      add_item(8'h5A, 39);
      // Position 2 without a frame start, then a restarted start.
      add_item(ID_FIRST, 2);
      add_item(ID_FIRST, 0);
      add_item(ID_SECOND, 0);
      add_item(8'h27, 2);
   endtask

   // Sender: bursts of random length with random gaps, now and then one long burst.
   task automatic send_queued();
      int burst;
      int gap;
      while (minor_bytes_q.size() != 0) begin
         burst = ($urandom_range(0, 3) == 0) ? 400 : $urandom_range(1, 16);
         while (burst != 0 && minor_bytes_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= minor_bytes_q[0];
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            tracker.note_byte(minor_bytes_q.pop_front());
            burst--;
         end
         gap = $urandom_range(0, 8);
         if (gap != 0 || minor_bytes_q.size() == 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Waits until every block beat due has arrived and the pipeline has emptied.
   task automatic settle();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(logic [4:0] lo, logic [4:0] hi, logic [4:0] hdb);
      logic [4:0] vals[3];
      logic [1:0] idx[3];
      int         k;
      vals = '{lo, hi, hdb};
      idx  = '{CSR_EDB_MIN, CSR_EDB_MAX, CSR_HDB_CNT};
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.write_limit(idx[k], vals[k]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      tracker = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset limits, then wide and narrow ranges, both extremes, and an empty EDB range.
      gen_directed();
      gen_random(20);
      send_queued();
      settle();
      write_limits(5'd0, 5'd4, 5'd0);
      gen_random(25);
      send_queued();
      settle();
      write_limits(5'd31, 5'd31, 5'd31);
      gen_random(10);
      send_queued();
      settle();
      write_limits(5'd1, 5'd3, 5'd2);
      gen_random(20);
      send_queued();
      settle();
      write_limits(5'd5, 5'd0, 5'd1);
      gen_random(10);
      send_queued();
      settle();

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
